@@ hw/rtl/countdown_timer_bank_top_assert.svh @@
// Assertion macros shared by the timer bank RTL.
`ifndef COUNTDOWN_TIMER_BANK_TOP_ASSERT_SVH
`define COUNTDOWN_TIMER_BANK_TOP_ASSERT_SVH
// Implication checked on every rising clock edge, disabled in reset.
`define CTB_ASSERT_IMP(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error("assertion failed");
// Next-cycle implication, disabled in reset.
`define CTB_ASSERT_NXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

@@ hw/rtl/ctb_pkg.sv @@
// ----------------------------------------------------------------------------
// ctb_pkg
// Types and constants of the countdown timer bank.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package ctb_pkg;
  localparam int unsigned NumTimers = 16;
  localparam int unsigned NumSlots  = 8;
  localparam int unsigned TidW      = $clog2(NumTimers) > 0 ? $clog2(NumTimers) : 1;
  localparam int unsigned SidW      = $clog2(NumSlots) > 0 ? $clog2(NumSlots) : 1;
  localparam int unsigned ScntW     = $clog2(NumSlots + 1);

  typedef enum logic [3:0] {
    ReqInit = 4'd0, ReqStart = 4'd1, ReqRestart = 4'd2, ReqPause = 4'd3,
    ReqStop = 4'd4, ReqDelete = 4'd5, ReqTick = 4'd6, ReqFetch = 4'd7,
    ReqNext = 4'd8
  } req_e;

  typedef enum logic [1:0] {
    StOk = 2'd0, StInval = 2'd1, StNotRun = 2'd2, StFull = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    SIdle, SScan, SApply, SPend, SOut
  } state_e;

  typedef struct packed {
    logic [3:0]  req_type;
    logic [3:0]  timer_id;
    logic [31:0] period;
    logic        periodic_mode;
    logic [31:0] tick_count;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        wake;
    logic        found;
    logic [3:0]  fetched_timer;
    logic [31:0] next_expiry;
    logic        pending;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture request
    logic scan_clr;  // reset slot counter
    logic scan_en;   // process one slot
    logic apply;     // single-timer commands
    logic pend_en;   // pending scan step
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_last;
    logic need_scan;
    logic stop_scan;
  } sts_t;
endpackage
`default_nettype wire

@@ hw/rtl/ctb_ctrl.sv @@
// ----------------------------------------------------------------------------
// ctb_ctrl
// Command sequencer: accept, slot scan, apply, pending scan, respond.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "countdown_timer_bank_top_assert.svh"
module ctb_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  wire ctb_pkg::sts_t sts_i,
  output ctb_pkg::ctl_t      ctl_o
);
  ctb_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ctb_pkg::SIdle;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ctb_pkg::SIdle: if (in_valid_i) state_d = ctb_pkg::SScan;
      ctb_pkg::SScan: begin
        if (!sts_i.need_scan || sts_i.stop_scan || sts_i.scan_last)
          state_d = ctb_pkg::SApply;
      end
      ctb_pkg::SApply: state_d = ctb_pkg::SPend;
      ctb_pkg::SPend: if (sts_i.scan_last) state_d = ctb_pkg::SOut;
      ctb_pkg::SOut: if (out_ready_i) state_d = ctb_pkg::SIdle;
      default: state_d = ctb_pkg::SIdle;
    endcase
  end

  always_comb begin
    ctl_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ctb_pkg::SIdle: begin
        in_ready_o     = 1'b1;
        ctl_o.load     = in_valid_i;
        ctl_o.scan_clr = 1'b1;
      end
      ctb_pkg::SScan: ctl_o.scan_en = sts_i.need_scan && !sts_i.stop_scan;
      ctb_pkg::SApply: begin
        ctl_o.apply    = 1'b1;
        ctl_o.scan_clr = 1'b1;
      end
      ctb_pkg::SPend: ctl_o.pend_en = 1'b1;
      ctb_pkg::SOut: out_valid_o = 1'b1;
      default: ;
    endcase
  end

  `CTB_ASSERT_IMP(a_excl, clk_i, rst_ni, 1'b1, !(in_ready_o && out_valid_o))
  `CTB_ASSERT_NXT(a_acc, clk_i, rst_ni, in_valid_i && in_ready_o, state_q == ctb_pkg::SScan)
  `CTB_ASSERT_NXT(a_apply, clk_i, rst_ni, state_q == ctb_pkg::SApply,
                  state_q == ctb_pkg::SPend)
endmodule
`default_nettype wire

@@ hw/rtl/ctb_dp.sv @@
// ----------------------------------------------------------------------------
// ctb_dp
// Timer and slot registers, one slot per cycle scan unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "countdown_timer_bank_top_assert.svh"
module ctb_dp (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire ctb_pkg::req_t req_i,
  input  wire ctb_pkg::ctl_t ctl_i,
  output ctb_pkg::sts_t      sts_o,
  output ctb_pkg::rsp_t      rsp_o
);
  localparam int unsigned NT = ctb_pkg::NumTimers;
  localparam int unsigned NS = ctb_pkg::NumSlots;

  ctb_pkg::req_t req_q;
  logic [31:0] per_q [NT];
  logic [31:0] rem_q [NT];
  logic [NT-1:0] prd_q, act_q, pau_q, exp_q;
  logic [NS-1:0] sv_q;
  logic [3:0] st_q [NS];  // slot timer, valid only with sv_q
  logic [ctb_pkg::ScntW-1:0] sc_q;
  // scan results
  logic hit_q, free_ok_q, done_q, wake_q, found_q, pend_q;
  logic [ctb_pkg::SidW-1:0] hit_s_q, free_s_q;
  logic [3:0] fet_q;
  logic [31:0] nxt_q;
  logic [1:0] status_q;

  logic [ctb_pkg::SidW-1:0] si;
  logic [3:0] tcur;
  logic [ctb_pkg::TidW-1:0] ti, rid;
  logic tin, id_ok, is_arm, is_rel;

  assign si    = sc_q[ctb_pkg::SidW-1:0];
  assign tcur  = st_q[si];
  assign tin   = ({28'd0, tcur} < NT);
  assign ti    = tcur[ctb_pkg::TidW-1:0];
  assign id_ok = ({28'd0, req_q.timer_id} < NT);
  assign rid   = req_q.timer_id[ctb_pkg::TidW-1:0];
  assign is_arm = (req_q.req_type == ctb_pkg::ReqStart) ||
                  (req_q.req_type == ctb_pkg::ReqRestart);
  assign is_rel = (req_q.req_type == ctb_pkg::ReqInit && req_q.period != '0) ||
                  req_q.req_type == ctb_pkg::ReqStop ||
                  req_q.req_type == ctb_pkg::ReqDelete;

  assign sts_o.scan_last = (sc_q >= ctb_pkg::ScntW'(NS - 1));
  assign sts_o.need_scan = ((is_rel || (is_arm && per_q[rid] != '0)) && id_ok) ||
                           (req_q.req_type == ctb_pkg::ReqTick && req_q.tick_count != '0) ||
                           req_q.req_type == ctb_pkg::ReqFetch ||
                           req_q.req_type == ctb_pkg::ReqNext;
  assign sts_o.stop_scan = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prd_q <= '0; act_q <= '0; pau_q <= '0; exp_q <= '0; sv_q <= '0;
      sc_q <= '0; hit_q <= 1'b0; free_ok_q <= 1'b0; done_q <= 1'b0;
      wake_q <= 1'b0; found_q <= 1'b0; pend_q <= 1'b0;
      hit_s_q <= '0; free_s_q <= '0; fet_q <= '0; nxt_q <= '0; status_q <= '0;
      for (int i = 0; i < NT; i++) begin
        per_q[i] <= '0; rem_q[i] <= '0;
      end
    end else begin
      if (ctl_i.load) begin
        hit_q <= 1'b0; free_ok_q <= 1'b0; done_q <= 1'b0; wake_q <= 1'b0;
        found_q <= 1'b0; fet_q <= '0; pend_q <= 1'b0; status_q <= ctb_pkg::StOk;
        nxt_q <= (req_i.req_type == ctb_pkg::ReqNext) ? '1 : '0;
      end
      if (ctl_i.scan_clr) sc_q <= '0;
      if (ctl_i.scan_en) begin
        sc_q <= sc_q + 1'b1;
        case (req_q.req_type)
          ctb_pkg::ReqTick: begin
            if (sv_q[si] && tin && act_q[ti]) begin
              if (rem_q[ti] > req_q.tick_count) begin
                rem_q[ti] <= rem_q[ti] - req_q.tick_count;
              end else begin
                if (prd_q[ti]) rem_q[ti] <= per_q[ti];
                else act_q[ti] <= 1'b0;
                exp_q[ti] <= 1'b1;
                wake_q <= 1'b1;
              end
            end
          end
          ctb_pkg::ReqFetch: begin
            if (sv_q[si] && tin && exp_q[ti]) begin
              exp_q[ti] <= 1'b0;
              if (!act_q[ti]) sv_q[si] <= 1'b0;
              found_q <= 1'b1; fet_q <= tcur; done_q <= 1'b1;
            end
          end
          ctb_pkg::ReqNext: begin
            if (sv_q[si] && tin && act_q[ti] && rem_q[ti] < nxt_q) nxt_q <= rem_q[ti];
          end
          default: begin  // slot lookup for the addressed timer and the first free slot
            if (sv_q[si] && tcur == req_q.timer_id) begin
              hit_q <= 1'b1; hit_s_q <= si; done_q <= 1'b1;
            end else if (!sv_q[si] && !free_ok_q) begin
              free_ok_q <= 1'b1; free_s_q <= si;
            end
          end
        endcase
      end
      if (ctl_i.apply) begin
        if (req_q.req_type <= ctb_pkg::ReqDelete && !id_ok) begin
          status_q <= ctb_pkg::StInval;
        end else begin
          case (req_q.req_type)
            ctb_pkg::ReqInit: begin
              if (req_q.period == '0) status_q <= ctb_pkg::StInval;
              else begin
                if (hit_q) sv_q[hit_s_q] <= 1'b0;
                per_q[rid] <= req_q.period; rem_q[rid] <= req_q.period;
                prd_q[rid] <= req_q.periodic_mode;
                act_q[rid] <= 1'b0; pau_q[rid] <= 1'b0; exp_q[rid] <= 1'b0;
              end
            end
            ctb_pkg::ReqStart, ctb_pkg::ReqRestart: begin
              if (per_q[rid] == '0) status_q <= ctb_pkg::StInval;
              else if (!hit_q && !free_ok_q) status_q <= ctb_pkg::StFull;
              else begin
                if (!hit_q) begin
                  sv_q[free_s_q] <= 1'b1; st_q[free_s_q] <= req_q.timer_id;
                end
                if (req_q.req_type == ctb_pkg::ReqRestart || !pau_q[rid]) begin
                  rem_q[rid] <= per_q[rid]; exp_q[rid] <= 1'b0;
                end
                pau_q[rid] <= 1'b0; act_q[rid] <= 1'b1;
              end
            end
            ctb_pkg::ReqPause: begin
              if (act_q[rid]) begin
                act_q[rid] <= 1'b0; pau_q[rid] <= 1'b1;
              end else if (!pau_q[rid]) status_q <= ctb_pkg::StNotRun;
            end
            ctb_pkg::ReqStop, ctb_pkg::ReqDelete: begin
              act_q[rid] <= 1'b0; pau_q[rid] <= 1'b0; exp_q[rid] <= 1'b0;
              if (hit_q) sv_q[hit_s_q] <= 1'b0;
              if (req_q.req_type == ctb_pkg::ReqDelete) begin
                per_q[rid] <= '0; rem_q[rid] <= '0;
              end
            end
            ctb_pkg::ReqTick, ctb_pkg::ReqFetch, ctb_pkg::ReqNext: ;
            default: status_q <= ctb_pkg::StInval;
          endcase
        end
      end
      if (ctl_i.pend_en) begin
        sc_q <= sc_q + 1'b1;
        if (sv_q[si] && tin && exp_q[ti]) pend_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) req_q <= req_i;
  end

  assign rsp_o.status        = status_q;
  assign rsp_o.wake          = wake_q;
  assign rsp_o.found         = found_q;
  assign rsp_o.fetched_timer = fet_q;
  assign rsp_o.next_expiry   = nxt_q;
  assign rsp_o.pending       = pend_q;

  `CTB_ASSERT_IMP(a_fnd, clk_i, rst_ni, !found_q, fet_q == '0)
  `CTB_ASSERT_NXT(a_ld, clk_i, rst_ni, ctl_i.load, !done_q && !wake_q)
  `CTB_ASSERT_IMP(a_one, clk_i, rst_ni, 1'b1, $countones({ctl_i.load, ctl_i.scan_en,
                  ctl_i.apply, ctl_i.pend_en}) <= 1)
endmodule
`default_nettype wire

@@ hw/rtl/countdown_timer_bank_top.sv @@
// ----------------------------------------------------------------------------
// countdown_timer_bank_top
// Bank of one-shot/periodic countdown timers with a slot registry.
// ----------------------------------------------------------------------------
// channel | direction | handshake               | payload
// req     | in        | req_valid_i/req_ready_o | req_i   (ctb_pkg::req_t)
// rsp     | out       | rsp_valid_o/rsp_ready_i | rsp_o   (ctb_pkg::rsp_t)
//
// One command at a time, in order: accept, slot scan (tick/fetch/query/
// arm/release; fetch and lookups stop early), apply, a pending scan over
// all slots, and the result.
// The slot registry is walked one slot per cycle by one shared compare unit.
// Reset clears all timers and slots; no clearing pass.
// A stalled result holds until taken; no new command enters meanwhile.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module countdown_timer_bank_top (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          req_valid_i,
  output logic               req_ready_o,
  input  wire ctb_pkg::req_t req_i,
  output logic               rsp_valid_o,
  input  wire logic          rsp_ready_i,
  output ctb_pkg::rsp_t      rsp_o
);
  ctb_pkg::ctl_t ctl;
  ctb_pkg::sts_t sts;

  // sequencer
  ctb_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (req_valid_i), .in_ready_o (req_ready_o),
    .out_valid_o(rsp_valid_o), .out_ready_i(rsp_ready_i),
    .sts_i (sts), .ctl_o (ctl)
  );

  // timer state and scan datapath
  ctb_dp u_dp (
    .clk_i, .rst_ni,
    .req_i, .ctl_i (ctl), .sts_o (sts), .rsp_o
  );
endmodule
`default_nettype wire

@@ test/tb_countdown_timer_bank_top.sv @@
// ----------------------------------------------------------------------------
// tb_countdown_timer_bank_top
// Self-checking bench for the countdown timer bank: a directed table of
// commands, a registry fill, then random command streams, all checked against a
// behavioral timer bank model under random bursts, gaps and receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_countdown_timer_bank_top;
  localparam int NT = ctb_pkg::NumTimers;
  localparam int NS = ctb_pkg::NumSlots;
  localparam int WatchdogLimit = 20000;
  localparam int RandItems = 800;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic req_valid_i = 1'b0;
  logic req_ready_o;
  ctb_pkg::req_t req_i = '0;
  logic rsp_valid_o;
  logic rsp_ready_i = 1'b0;
  ctb_pkg::rsp_t rsp_o;

  always #5 clk_i = ~clk_i;

  countdown_timer_bank_top dut (
    .clk_i, .rst_ni, .req_valid_i, .req_ready_o, .req_i,
    .rsp_valid_o, .rsp_ready_i, .rsp_o
  );

  // behavioral copy of the timer bank
  logic [31:0] m_period [NT];
  logic [31:0] m_remain [NT];
  logic        m_periodic [NT];
  logic        m_active [NT];
  logic        m_paused [NT];
  logic        m_expired [NT];
  logic        m_slot_v [NS];
  logic [3:0]  m_slot_t [NS];

  ctb_pkg::rsp_t expected_rsp_q[$];
  int   errors = 0;
  int   n_sent = 0;
  int   n_rcvd = 0;
  int   n_wake = 0;
  int   n_found = 0;
  int   n_full = 0;
  bit   stim_done = 0;
  bit   hold_off = 0;

  function automatic int find_slot(input logic [3:0] id);
    for (int s = 0; s < NS; s++)
      if (m_slot_v[s] && m_slot_t[s] == id) return s;
    return NS;
  endfunction

  function automatic void drop_slot(input logic [3:0] id);
    int s;
    s = find_slot(id);
    if (s < NS) m_slot_v[s] = 1'b0;
  endfunction

  function automatic ctb_pkg::status_e arm_timer(input logic [3:0] id, input bit reload);
    int s;
    s = find_slot(id);
    if (m_period[id] == 0) return ctb_pkg::StInval;
    if (s == NS)
      for (int k = NS - 1; k >= 0; k--) if (!m_slot_v[k]) s = k;
    if (s == NS) return ctb_pkg::StFull;
    m_slot_v[s] = 1'b1;
    m_slot_t[s] = id;
    if (reload || !m_paused[id]) begin
      m_remain[id] = m_period[id];
      m_expired[id] = 1'b0;
    end
    m_paused[id] = 1'b0;
    m_active[id] = 1'b1;
    return ctb_pkg::StOk;
  endfunction

  function automatic void clear_timer_run(input logic [3:0] id);
    m_active[id] = 0; m_paused[id] = 0; m_expired[id] = 0;
    drop_slot(id);
  endfunction

  // next response of the timer bank for one command
  function automatic ctb_pkg::rsp_t timer_bank_step(input ctb_pkg::req_t r);
    ctb_pkg::rsp_t o;
    logic [3:0] t;
    o = '0;
    case (r.req_type)
      ctb_pkg::ReqInit: begin
        if (r.period == 0) o.status = ctb_pkg::StInval;
        else begin
          drop_slot(r.timer_id);
          m_period[r.timer_id] = r.period;
          m_remain[r.timer_id] = r.period;
          m_periodic[r.timer_id] = r.periodic_mode;
          m_active[r.timer_id] = 0; m_paused[r.timer_id] = 0;
          m_expired[r.timer_id] = 0;
        end
      end
      ctb_pkg::ReqStart:   o.status = arm_timer(r.timer_id, 1'b0);
      ctb_pkg::ReqRestart: o.status = arm_timer(r.timer_id, 1'b1);
      ctb_pkg::ReqPause: begin
        if (m_active[r.timer_id]) begin
          m_active[r.timer_id] = 0; m_paused[r.timer_id] = 1;
        end else if (!m_paused[r.timer_id]) o.status = ctb_pkg::StNotRun;
      end
      ctb_pkg::ReqStop: clear_timer_run(r.timer_id);
      ctb_pkg::ReqDelete: begin
        clear_timer_run(r.timer_id);
        m_period[r.timer_id] = 0; m_remain[r.timer_id] = 0;
      end
      ctb_pkg::ReqTick: begin
        if (r.tick_count != 0)
          for (int s = 0; s < NS; s++) begin
            t = m_slot_t[s];
            if (m_slot_v[s] && m_active[t]) begin
              if (m_remain[t] > r.tick_count) m_remain[t] -= r.tick_count;
              else begin
                if (m_periodic[t]) m_remain[t] = m_period[t];
                else m_active[t] = 0;
                m_expired[t] = 1; o.wake = 1;
              end
            end
          end
      end
      ctb_pkg::ReqFetch: begin
        for (int s = 0; s < NS; s++) begin
          t = m_slot_t[s];
          if (m_slot_v[s] && m_expired[t]) begin
            m_expired[t] = 0;
            if (!m_active[t]) m_slot_v[s] = 0;
            o.found = 1; o.fetched_timer = t;
            break;
          end
        end
      end
      ctb_pkg::ReqNext: begin
        o.next_expiry = '1;
        for (int s = 0; s < NS; s++) begin
          t = m_slot_t[s];
          if (m_slot_v[s] && m_active[t] && m_remain[t] < o.next_expiry)
            o.next_expiry = m_remain[t];
        end
      end
      default: o.status = ctb_pkg::StInval;
    endcase
    for (int s = 0; s < NS; s++)
      if (m_slot_v[s] && m_expired[m_slot_t[s]]) o.pending = 1;
    return o;
  endfunction

  // directed table; chk marks rows whose response is typed in
  typedef struct {
    ctb_pkg::req_t r;
    bit            chk;
    ctb_pkg::rsp_t e;
  } row_t;

  function automatic ctb_pkg::req_t mk(input logic [3:0] op, input logic [3:0] id,
                                       input logic [31:0] per, input logic md,
                                       input logic [31:0] n);
    ctb_pkg::req_t r;
    r.req_type = op; r.timer_id = id; r.period = per;
    r.periodic_mode = md; r.tick_count = n;
    return r;
  endfunction

  function automatic ctb_pkg::rsp_t st(input ctb_pkg::status_e s);
    ctb_pkg::rsp_t o;
    o = '0; o.status = s;
    return o;
  endfunction

  row_t dir_tab[$];

  function automatic void build_table();
    ctb_pkg::rsp_t nx;
    nx = '0; nx.next_expiry = '1;
    dir_tab.push_back('{mk(ctb_pkg::ReqNext, 0, 0, 0, 0), 1, nx});  // empty after reset
    dir_tab.push_back('{mk(ctb_pkg::ReqFetch, 0, 0, 0, 0), 1, st(ctb_pkg::StOk)});
    dir_tab.push_back('{mk(ctb_pkg::ReqStart, 3, 0, 0, 0), 1, st(ctb_pkg::StInval)});
    dir_tab.push_back('{mk(ctb_pkg::ReqRestart, 3, 0, 0, 0), 1, st(ctb_pkg::StInval)});
    dir_tab.push_back('{mk(ctb_pkg::ReqInit, 3, 0, 1, 0), 1, st(ctb_pkg::StInval)});
    dir_tab.push_back('{mk(ctb_pkg::ReqPause, 3, 0, 0, 0), 1, st(ctb_pkg::StNotRun)});
    dir_tab.push_back('{mk(ctb_pkg::ReqStop, 9, 0, 0, 0), 1, st(ctb_pkg::StOk)});
    dir_tab.push_back('{mk(ctb_pkg::ReqDelete, 9, 0, 0, 0), 1, st(ctb_pkg::StOk)});
    dir_tab.push_back('{mk(4'd9, 0, 0, 0, 0), 1, st(ctb_pkg::StInval)});  // unknown ops
    dir_tab.push_back('{mk(4'd15, 15, '1, 1, '1), 1, st(ctb_pkg::StInval)});
    dir_tab.push_back('{mk(ctb_pkg::ReqInit, 0, 32'd5, 0, 0), 1, st(ctb_pkg::StOk)});
    dir_tab.push_back('{mk(ctb_pkg::ReqInit, 15, '1, 1, 0), 1, st(ctb_pkg::StOk)});
    dir_tab.push_back('{mk(ctb_pkg::ReqInit, 1, 32'd1, 1, 0), 0, '0});
    dir_tab.push_back('{mk(ctb_pkg::ReqStart, 0, 0, 0, 0), 0, '0});
    dir_tab.push_back('{mk(ctb_pkg::ReqRestart, 15, 0, 0, 0), 0, '0});
    dir_tab.push_back('{mk(ctb_pkg::ReqStart, 1, 0, 0, 0), 0, '0});
    dir_tab.push_back('{mk(ctb_pkg::ReqTick, 0, 0, 0, 0), 0, '0});      // zero tick
    dir_tab.push_back('{mk(ctb_pkg::ReqTick, 0, 0, 0, 32'd3), 0, '0});
    dir_tab.push_back('{mk(ctb_pkg::ReqPause, 0, 0, 0, 0), 0, '0});
    dir_tab.push_back('{mk(ctb_pkg::ReqPause, 0, 0, 0, 0), 0, '0});     // already paused
    dir_tab.push_back('{mk(ctb_pkg::ReqStart, 0, 0, 0, 0), 0, '0});     // resume
    dir_tab.push_back('{mk(ctb_pkg::ReqTick, 0, 0, 0, '1), 0, '0});     // max tick
    dir_tab.push_back('{mk(ctb_pkg::ReqNext, 0, 0, 0, 0), 0, '0});
    dir_tab.push_back('{mk(ctb_pkg::ReqFetch, 0, 0, 0, 0), 0, '0});
    dir_tab.push_back('{mk(ctb_pkg::ReqInit, 1, 32'd7, 0, 0), 0, '0});  // re-init armed
    dir_tab.push_back('{mk(ctb_pkg::ReqDelete, 15, 0, 0, 0), 0, '0});
  endfunction

  // random command, mostly well formed, biased to small periods and ticks
  function automatic ctb_pkg::req_t rand_req();
    ctb_pkg::req_t r;
    logic [95:0] noise;
    int k;
    r = mk(4'($urandom_range(0, 8)), 4'($urandom_range(0, 15)), $urandom_range(1, 40),
           1'($urandom_range(0, 1)), $urandom_range(0, 20));
    noise = {$urandom, $urandom, $urandom};
    k = $urandom_range(0, 99);
    if (k < 4) r = noise[$bits(ctb_pkg::req_t)-1:0];   // raw noise, all fields
    else if (k < 8) r.period = $urandom;
    else if (k < 11) r.tick_count = $urandom;
    else if (k < 13) r.req_type = 4'($urandom_range(9, 15));
    else if (k < 30) r.req_type = ctb_pkg::ReqTick;
    else if (k < 42) r.req_type = ctb_pkg::ReqFetch;
    return r;
  endfunction

  // drive one command; valid stays up across back-to-back transfers
  task automatic send_req(input ctb_pkg::req_t r);
    req_valid_i <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (!req_ready_o) @(posedge clk_i);
    expected_rsp_q.push_back(timer_bank_step(r));
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic idle_gap();
    int g;
    g = $urandom_range(0, 3) == 0 ? $urandom_range(1, 12) : 0;
    if (g != 0) begin
      req_valid_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
  endtask

  initial begin
    row_t rw;
    int burst;
    for (int i = 0; i < NT; i++) begin
      m_period[i] = 0; m_remain[i] = 0; m_periodic[i] = 0;
      m_active[i] = 0; m_paused[i] = 0; m_expired[i] = 0;
    end
    for (int s = 0; s < NS; s++) begin
      m_slot_v[s] = 0; m_slot_t[s] = 0;
    end
    build_table();
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    foreach (dir_tab[i]) begin
      rw = dir_tab[i];
      send_req(rw.r);
      // typed-in rows must agree with the model too
      if (rw.chk && expected_rsp_q[$] != rw.e) begin
        $display("%0t table row %0d: expected %h model %h", $time, i, rw.e,
                 expected_rsp_q[$]);
        errors++;
      end
      idle_gap();
    end
    // fill the registry while the receiver holds off
    hold_off = 1;
    for (int i = 0; i < NS + 2; i++) begin
      send_req(mk(ctb_pkg::ReqInit, 4'(i), 32'(i + 2), i[0], 32'd0));
      send_req(mk(ctb_pkg::ReqStart, 4'(i), 32'd0, 1'b0, 32'd0));
    end
    hold_off = 0;
    burst = 0;
    for (int i = 0; i < RandItems; i++) begin
      send_req(rand_req());
      if (++burst >= $urandom_range(1, 16) && i < RandItems - 1) begin
        burst = 0;
        idle_gap();
      end
    end
    req_valid_i <= 1'b0;
    stim_done = 1;
  end

  // receiver: stall pattern, plus the long hold-off
  initial begin
    int hold_cnt;
    hold_cnt = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off && hold_cnt < 400) begin
        hold_cnt++;
        rsp_ready_i <= 1'b0;
      end else case ($urandom_range(0, 7))
        0, 1:    rsp_ready_i <= 1'b0;
        default: rsp_ready_i <= 1'b1;
      endcase
    end
  end

  // response checker
  always @(posedge clk_i) begin
    ctb_pkg::rsp_t e;
    if (rst_ni && rsp_valid_o && rsp_ready_i) begin
      n_rcvd++;
      if (expected_rsp_q.size() == 0) begin
        $display("%0t unexpected response: actual %h", $time, rsp_o);
        errors++;
      end else begin
        e = expected_rsp_q.pop_front();
        if (e.wake) n_wake++;
        if (e.found) n_found++;
        if (e.status == ctb_pkg::StFull) n_full++;
        if (rsp_o.status !== e.status) begin
          $display("%0t status: expected %0d actual %0d", $time, e.status, rsp_o.status);
          errors++;
        end
        if (rsp_o.wake !== e.wake) begin
          $display("%0t wake: expected %0d actual %0d", $time, e.wake, rsp_o.wake);
          errors++;
        end
        if (rsp_o.found !== e.found) begin
          $display("%0t found: expected %0d actual %0d", $time, e.found, rsp_o.found);
          errors++;
        end
        if (rsp_o.fetched_timer !== e.fetched_timer) begin
          $display("%0t fetched_timer: expected %0d actual %0d", $time,
                   e.fetched_timer, rsp_o.fetched_timer);
          errors++;
        end
        if (rsp_o.next_expiry !== e.next_expiry) begin
          $display("%0t next_expiry: expected %h actual %h", $time,
                   e.next_expiry, rsp_o.next_expiry);
          errors++;
        end
        if (rsp_o.pending !== e.pending) begin
          $display("%0t pending: expected %0d actual %0d", $time, e.pending, rsp_o.pending);
          errors++;
        end
      end
    end
  end

  // watchdog on stalled handshakes, then end of run
  initial begin
    int quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (!(stim_done && expected_rsp_q.size() == 0)) begin
      @(posedge clk_i);
      if ((req_valid_i && req_ready_o) || (rsp_valid_o && rsp_ready_i)) quiet = 0;
      else quiet++;
      if (quiet >= WatchdogLimit) begin
        $display("%0t watchdog: no transfer for %0d cycles", $time, quiet);
        $display("tb_countdown_timer_bank_top: errors");
        $finish;
      end
    end
    repeat (40) @(posedge clk_i);
    $display("covered %0d commands, %0d responses: %0d wakes, %0d fetches, %0d full",
             n_sent, n_rcvd, n_wake, n_found, n_full);
    if (errors == 0) $display("tb_countdown_timer_bank_top: clean");
    else $display("tb_countdown_timer_bank_top: errors");
    $finish;
  end
endmodule
